FILE: design/adaptive_traffic_generator_defines.svh
// Assertion macros shared by the traffic generator RTL.
`ifndef ADAPTIVE_TRAFFIC_GENERATOR_DEFINES_SVH
`define ADAPTIVE_TRAFFIC_GENERATOR_DEFINES_SVH

// Condition implies property in the same cycle.
`define ATG_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("traffic generator check failed");

// Condition implies property in the next cycle.
`define ATG_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("traffic generator check failed");

`endif

FILE: design/atg_pkg.sv
// ----------------------------------------------------------------------------
// atg_pkg
// Codes, widths and the result record of the adaptive traffic generator.
// ----------------------------------------------------------------------------
`default_nettype none

package atg_pkg;

   localparam int RATE_W = 40;
   localparam int TICK_W = 64;
   localparam int LEN_W  = 16;
   localparam int IDX_W  = 3;

   // event codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_SEND  = 2'd1;
   localparam logic [1:0] OP_LOSS  = 2'd2;
   localparam logic [1:0] OP_RX    = 2'd3;

   // scheduled event kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_SEND = 2'd1;
   localparam logic [1:0] KIND_LOSS = 2'd2;

   // modes
   localparam logic [1:0] MODE_STATIC = 2'd0;
   localparam logic [1:0] MODE_INCR   = 2'd1;
   localparam logic [1:0] MODE_BURST  = 2'd2;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [IDX_W-1:0] CSR_PACKET     = 3'd1;
   localparam logic [IDX_W-1:0] CSR_START_RATE = 3'd2;
   localparam logic [IDX_W-1:0] CSR_STOP       = 3'd3;
   localparam logic [IDX_W-1:0] CSR_LOSS_INT   = 3'd4;
   localparam logic [IDX_W-1:0] CSR_LOSS_WAIT  = 3'd5;
   localparam logic [IDX_W-1:0] CSR_BURST_W    = 3'd6;
   localparam logic [IDX_W-1:0] CSR_BURST_GAP  = 3'd7;

   localparam logic [LEN_W-1:0] MIN_FRAME  = 16'd22;
   localparam int               LOSS_LIMIT = 10;

   typedef struct packed {
      logic              tx_valid;
      logic [TICK_W-1:0] tx_timestamp;
      logic [LEN_W-1:0]  tx_length;
      logic [1:0]        next_kind;
      logic [TICK_W-1:0] next_tick;
      logic              rx_counted;
      logic [TICK_W-1:0] latency_ticks;
      logic              min_rate_hit;
   } res_type;

endpackage

`default_nettype wire

FILE: design/atg_div.sv
// ----------------------------------------------------------------------------
// atg_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module atg_div #(
   parameter int W = 40
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0]  rem_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  dvs_ff;

   logic [W:0]    trial;
   logic [W:0]    diff;
   logic          fits;
   logic [W-1:0]  rem_in;
   logic [W-1:0]  quo_in;

   // shift the next dividend bit into the remainder, subtract when it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in = fits ? diff[W-1:0] : trial[W-1:0];
      quo_in = {quo_ff[W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: design/adaptive_traffic_generator.sv
// ----------------------------------------------------------------------------
// adaptive_traffic_generator
// Event-driven packet scheduler with static, loss-probing and burst modes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | event, tick and received frame
//  rsp     | out       | rsp_valid/rsp_stall | frame request, next event, rate
//  csr     | in        | csr_write           | csr_index, csr_data
//
//  One event at a time, from one accepted transfer to the next: start,
//  received frame and any event that schedules nothing pass S_PREP and
//  S_DONE; a send due adds one divider pass, S_SEL and S_SCHED, and a loss
//  check adds two passes. Each pass of the bit-serial divider holds its wait
//  state until the done flag: one pass for the period, one for the rate step.
//  Synchronous reset clears the rate to one and all counters.
//  A finished result waits in the output register while the next event is
//  taken; a held rsp_stall only delays the hand-over at the end of an event.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adaptive_traffic_generator_defines.svh"

module adaptive_traffic_generator #(
   parameter logic [63:0] TICKS_PER_SECOND = 64'd1000000000000,
   parameter int          COUNT_WIDTH      = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_op,
   input  wire logic [atg_pkg::TICK_W-1:0]   req_now,
   input  wire logic [atg_pkg::TICK_W-1:0]   req_start_at,
   input  wire logic                         req_link_accepted,
   input  wire logic [atg_pkg::LEN_W-1:0]    req_rx_length,
   input  wire logic                         req_rx_address_match,
   input  wire logic [atg_pkg::TICK_W-1:0]   req_rx_timestamp,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_tx_valid,
   output logic [atg_pkg::TICK_W-1:0]        rsp_tx_timestamp,
   output logic [atg_pkg::LEN_W-1:0]         rsp_tx_length,
   output logic [1:0]                        rsp_next_kind,
   output logic [atg_pkg::TICK_W-1:0]        rsp_next_tick,
   output logic [atg_pkg::RATE_W-1:0]        rsp_current_rate,
   output logic                              rsp_rx_counted,
   output logic [atg_pkg::TICK_W-1:0]        rsp_latency_ticks,
   output logic                              rsp_min_rate_hit,
   input  wire logic                         csr_write,
   input  wire logic [atg_pkg::IDX_W-1:0]    csr_index,
   input  wire logic [atg_pkg::TICK_W-1:0]   csr_data
);

   import atg_pkg::*;

   localparam logic [RATE_W-1:0] TPS      = TICKS_PER_SECOND[RATE_W-1:0];
   localparam logic [RATE_W-1:0] TPS_HALF = TPS >> 1;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_PREP     = 9'b000000010,
      S_DIV_STEP = 9'b000000100,
      S_ADJ      = 9'b000001000,
      S_PER_GO   = 9'b000010000,
      S_DIV_PER  = 9'b000100000,
      S_SEL      = 9'b001000000,
      S_SCHED    = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   // configuration
   logic [1:0]        mode_ff;
   logic [LEN_W-1:0]  psize_ff;
   logic [RATE_W-1:0] srate_ff;
   logic [TICK_W-1:0] stop_ff;
   logic [31:0]       lint_ff;
   logic [TICK_W-1:0] lwait_ff;
   logic [TICK_W-1:0] bwidth_ff;
   logic [TICK_W-1:0] bgap_ff;

   // latched event
   logic [1:0]        op_ff;
   logic [TICK_W-1:0] sa_ff;
   logic              link_ff;
   logic [LEN_W-1:0]  rxlen_ff;
   logic              rxmatch_ff;
   logic [TICK_W-1:0] rxts_ff;

   state_type              state_ff, state_in;
   logic [TICK_W-1:0]      now_ff, now_in;
   logic [TICK_W-1:0]      room_ff, room_in;
   logic [RATE_W-1:0]      rate_ff, rate_in;
   logic [TICK_W-1:0]      burst_ff, burst_in;
   logic [COUNT_WIDTH-1:0] sent_ff, sent_in;
   logic [COUNT_WIDTH-1:0] recv_ff, recv_in;
   res_type                res_ff, res_in;
   logic [TICK_W-1:0]      delay_ff, delay_in;
   logic [1:0]             kind_ff, kind_in;
   logic                   chain_ff, chain_in;
   logic                   bflag_ff, bflag_in;
   logic                   losshi_ff, losshi_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   res_type                rsp_ff, rsp_in;
   logic [RATE_W-1:0]      rsp_rate_ff, rsp_rate_in;

   // divider
   logic              div_start;
   logic [RATE_W-1:0] div_dividend;
   logic [RATE_W-1:0] div_divisor;
   logic              div_done;
   logic [RATE_W-1:0] div_quo;

   logic              req_accept;
   logic [TICK_W-1:0] first_tick;
   logic [RATE_W-1:0] rate_clamp;
   logic [RATE_W-1:0] step_div;
   logic [RATE_W-1:0] step_val;
   logic [TICK_W-1:0] per_val;

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;

   assign first_tick = (now_ff > sa_ff) ? now_ff : sa_ff;
   assign rate_clamp = (srate_ff == '0) ? RATE_W'(1)
                     : ((srate_ff > TPS) ? TPS : srate_ff);
   assign step_div   = (psize_ff == '0) ? RATE_W'(1) : RATE_W'({psize_ff, 3'b000});
   assign step_val   = (div_quo == '0) ? RATE_W'(1) : div_quo;
   assign per_val    = TICK_W'(div_quo);

   atg_div #(
      .W (RATE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      room_in      = room_ff;
      rate_in      = rate_ff;
      burst_in     = burst_ff;
      sent_in      = sent_ff;
      recv_in      = recv_ff;
      res_in       = res_ff;
      delay_in     = delay_ff;
      kind_in      = kind_ff;
      chain_in     = chain_ff;
      bflag_in     = bflag_ff;
      losshi_in    = losshi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rsp_rate_in  = rsp_rate_ff;
      div_start    = 1'b0;
      div_dividend = TPS;
      div_divisor  = rate_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_PREP;
               now_in   = req_now;
               res_in   = '0;
               chain_in = 1'b0;
               bflag_in = 1'b0;
            end
         end
         S_PREP: begin
            room_in  = stop_ff - now_ff;
            state_in = S_DONE;
            case (op_ff)
               OP_START: begin
                  rate_in = rate_clamp;
                  if (first_tick < stop_ff) begin
                     res_in.next_kind = KIND_SEND;
                     res_in.next_tick = first_tick + 1'b1;
                     if (mode_ff == MODE_BURST) begin
                        burst_in = first_tick + 1'b1;
                     end
                  end
               end
               OP_SEND: begin
                  if (now_ff <= stop_ff) begin
                     res_in.tx_valid     = 1'b1;
                     res_in.tx_timestamp = now_ff;
                     res_in.tx_length    = psize_ff;
                     if (link_ff) begin
                        sent_in = sent_ff + 1'b1;
                     end
                     if (now_ff < stop_ff && (mode_ff == MODE_STATIC
                           || mode_ff == MODE_INCR || mode_ff == MODE_BURST)) begin
                        div_start = 1'b1;
                        state_in  = S_DIV_PER;
                     end
                  end
               end
               OP_LOSS: begin
                  if (now_ff <= stop_ff) begin
                     losshi_in    = (sent_ff > recv_ff)
                        && ((sent_ff - recv_ff) >= COUNT_WIDTH'(LOSS_LIMIT));
                     div_start    = 1'b1;
                     div_dividend = TPS_HALF;
                     div_divisor  = step_div;
                     state_in     = S_DIV_STEP;
                  end
               end
               default: begin
                  if (rxlen_ff >= MIN_FRAME && rxmatch_ff && rxts_ff <= now_ff) begin
                     recv_in              = recv_ff + 1'b1;
                     res_in.rx_counted    = 1'b1;
                     res_in.latency_ticks = now_ff - rxts_ff;
                  end
               end
            endcase
         end
         S_DIV_STEP: begin
            if (div_done) begin
               state_in = S_ADJ;
            end
         end
         S_ADJ: begin
            if (!losshi_ff) begin
               if (step_val > TPS - rate_ff) begin
                  rate_in = TPS;
               end else begin
                  rate_in = rate_ff + step_val;
               end
            end else if (step_val >= rate_ff) begin
               rate_in             = RATE_W'(1);
               res_in.min_rate_hit = 1'b1;
            end else begin
               rate_in = rate_ff - step_val;
            end
            sent_in  = '0;
            recv_in  = '0;
            chain_in = losshi_ff;
            state_in = S_PER_GO;
         end
         S_PER_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_PER;
         end
         S_DIV_PER: begin
            if (div_done) begin
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            delay_in = per_val;
            kind_in  = KIND_SEND;
            state_in = S_SCHED;
            if (op_ff == OP_SEND) begin
               case (mode_ff)
                  MODE_INCR: begin
                     if (64'(sent_ff) == 64'(lint_ff)) begin
                        delay_in = lwait_ff;
                        kind_in  = KIND_LOSS;
                     end
                  end
                  MODE_BURST: begin
                     if ((now_ff - burst_ff) > bwidth_ff) begin
                        delay_in = bgap_ff;
                        bflag_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCHED: begin
            state_in = S_DONE;
            if (delay_ff <= room_ff) begin
               if (chain_ff) begin
                  // wait out in-flight frames after the period
                  now_in   = now_ff + delay_ff;
                  room_in  = room_ff - delay_ff;
                  delay_in = lwait_ff;
                  chain_in = 1'b0;
                  state_in = S_SCHED;
               end else begin
                  res_in.next_kind = kind_ff;
                  res_in.next_tick = now_ff + delay_ff;
                  if (bflag_ff) begin
                     burst_in = now_ff + delay_ff;
                  end
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               rsp_rate_in  = rate_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= RATE_W'(1);
         burst_ff     <= '0;
         sent_ff      <= '0;
         recv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         burst_ff     <= burst_in;
         sent_ff      <= sent_in;
         recv_ff      <= recv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      room_ff     <= room_in;
      res_ff      <= res_in;
      delay_ff    <= delay_in;
      kind_ff     <= kind_in;
      chain_ff    <= chain_in;
      bflag_ff    <= bflag_in;
      losshi_ff   <= losshi_in;
      rsp_ff      <= rsp_in;
      rsp_rate_ff <= rsp_rate_in;
   end

   // hold the event fields for the whole transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= req_op;
         sa_ff      <= req_start_at;
         link_ff    <= req_link_accepted;
         rxlen_ff   <= req_rx_length;
         rxmatch_ff <= req_rx_address_match;
         rxts_ff    <= req_rx_timestamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_STATIC;
         psize_ff  <= 16'd64;
         srate_ff  <= 40'd1000000;
         stop_ff   <= '1;
         lint_ff   <= 32'd1000;
         lwait_ff  <= 64'd1000000;
         bwidth_ff <= 64'd1000000;
         bgap_ff   <= 64'd1000000;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE:       mode_ff   <= csr_data[1:0];
            CSR_PACKET:     psize_ff  <= csr_data[LEN_W-1:0];
            CSR_START_RATE: srate_ff  <= csr_data[RATE_W-1:0];
            CSR_STOP:       stop_ff   <= csr_data;
            CSR_LOSS_INT:   lint_ff   <= csr_data[31:0];
            CSR_LOSS_WAIT:  lwait_ff  <= csr_data;
            CSR_BURST_W:    bwidth_ff <= csr_data;
            CSR_BURST_GAP:  bgap_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_valid      = rsp_ff.tx_valid;
   assign rsp_tx_timestamp  = rsp_ff.tx_timestamp;
   assign rsp_tx_length     = rsp_ff.tx_length;
   assign rsp_next_kind     = rsp_ff.next_kind;
   assign rsp_next_tick     = rsp_ff.next_tick;
   assign rsp_current_rate  = rsp_rate_ff;
   assign rsp_rx_counted    = rsp_ff.rx_counted;
   assign rsp_latency_ticks = rsp_ff.latency_ticks;
   assign rsp_min_rate_hit  = rsp_ff.min_rate_hit;

   `ATG_ASSERT_IMPLY(a_rate_range, clock, reset, 1'b1, rate_ff != '0 && rate_ff <= TPS)
   `ATG_ASSERT_NEXT(a_accept_prep, clock, reset, req_accept, state_ff == S_PREP)
   `ATG_ASSERT_IMPLY(a_no_sched_tick, clock, reset, rsp_valid && rsp_next_kind == KIND_NONE, rsp_next_tick == '0)

endmodule

`default_nettype wire

FILE: dv/tb_adaptive_traffic_generator.sv
// ----------------------------------------------------------------------------
// tb_adaptive_traffic_generator
// Drives scheduling events into the traffic generator under several register
// settings, predicts each result with a behavioural scoreboard and compares
// every field of every result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_adaptive_traffic_generator;
   timeunit 1ns;
   timeprecision 1ps;
   import atg_pkg::*;

   localparam logic [63:0] TPS      = 64'd1000000000000;
   localparam int          STALL_LIM = 20000;

   typedef struct {
      logic [1:0]  op;
      logic [63:0] now;
      logic [63:0] start_at;
      logic        link_accepted;
      logic [15:0] rx_length;
      logic        rx_address_match;
      logic [63:0] rx_timestamp;
   } event_type;

   typedef struct {
      logic        tx_valid;
      logic [63:0] tx_timestamp;
      logic [15:0] tx_length;
      logic [1:0]  next_kind;
      logic [63:0] next_tick;
      logic [39:0] current_rate;
      logic        rx_counted;
      logic [63:0] latency_ticks;
      logic        min_rate_hit;
   } outcome_type;

   int fail_count = 0;

   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   class scheduler_scoreboard;
      logic [1:0]  mode;
      logic [15:0] frame_bytes;
      logic [39:0] start_rate;
      logic [63:0] end_tick, loss_wait, burst_len, idle_len;
      logic [31:0] loss_interval;
      logic [63:0] rate, burst_start;
      logic [31:0] sent_count, received_count;
      outcome_type pending[$];

      function new();
         mode = MODE_STATIC; frame_bytes = 64; start_rate = 1000000;
         end_tick = '1; loss_interval = 1000; loss_wait = 1000000;
         burst_len = 1000000; idle_len = 1000000;
         rate = 1; burst_start = 0; sent_count = 0; received_count = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] v);
         case (idx)
            CSR_MODE:       mode = v[1:0];
            CSR_PACKET:     frame_bytes = v[15:0];
            CSR_START_RATE: start_rate = v[39:0];
            CSR_STOP:       end_tick = v;
            CSR_LOSS_INT:   loss_interval = v[31:0];
            CSR_LOSS_WAIT:  loss_wait = v;
            CSR_BURST_W:    burst_len = v;
            default:        idle_len = v;
         endcase
      endfunction

      function logic [63:0] period();
         return TPS / (rate == 0 ? 64'd1 : rate);
      endfunction

      function logic [63:0] step_size();
         logic [63:0] bits, s;
         bits = 64'(frame_bytes) * 8;
         s = (TPS / 2) / (bits == 0 ? 64'd1 : bits);
         return s == 0 ? 64'd1 : s;
      endfunction

      function bit fits(logic [63:0] now, logic [63:0] delay, output logic [63:0] t);
         t = 0;
         if (now > end_tick || delay > end_tick - now) return 0;
         t = now + delay;
         return 1;
      endfunction

      function void note_event(event_type e);
         outcome_type o;
         logic [63:0] first, t, loss, stp, per, room;
         o = '{default: 0};
         t = 0;
         case (e.op)
            OP_START: begin
               first = e.now > e.start_at ? e.now : e.start_at;
               rate = start_rate == 0 ? 64'd1 : (start_rate > TPS ? TPS : 64'(start_rate));
               if (first < end_tick) begin
                  if (mode == MODE_BURST) burst_start = first + 1;
                  o.next_kind = KIND_SEND;
                  o.next_tick = first + 1;
               end
            end
            OP_SEND: if (e.now <= end_tick) begin
               o.tx_valid = 1; o.tx_timestamp = e.now; o.tx_length = frame_bytes;
               if (e.link_accepted) sent_count++;
               if (e.now < end_tick) begin
                  if (mode == MODE_INCR) begin
                     if (64'(sent_count) == 64'(loss_interval)) begin
                        if (fits(e.now, loss_wait, t)) o.next_kind = KIND_LOSS;
                     end else if (fits(e.now, period(), t)) o.next_kind = KIND_SEND;
                  end else if (mode == MODE_STATIC) begin
                     if (fits(e.now, period(), t)) o.next_kind = KIND_SEND;
                  end else if (mode == MODE_BURST) begin
                     if (e.now - burst_start > burst_len) begin
                        if (fits(e.now, idle_len, t)) begin
                           o.next_kind = KIND_SEND;
                           burst_start = e.now + idle_len;
                        end
                     end else if (fits(e.now, period(), t)) o.next_kind = KIND_SEND;
                  end
                  if (o.next_kind != KIND_NONE) o.next_tick = t;
               end
            end
            OP_LOSS: if (e.now <= end_tick) begin
               loss = sent_count > received_count ? 64'(sent_count - received_count) : 0;
               stp = step_size();
               if (loss < LOSS_LIMIT) begin
                  if (stp > TPS - rate) rate = TPS; else rate += stp;
                  if (fits(e.now, period(), t)) begin
                     o.next_kind = KIND_SEND; o.next_tick = t;
                  end
               end else begin
                  if (stp >= rate) begin
                     rate = 1; o.min_rate_hit = 1;
                  end else rate -= stp;
                  per = period();
                  room = end_tick - e.now;
                  if (per <= room && loss_wait <= room - per) begin
                     o.next_kind = KIND_SEND; o.next_tick = e.now + per + loss_wait;
                  end
               end
               sent_count = 0; received_count = 0;
            end
            default: if (e.rx_length >= MIN_FRAME && e.rx_address_match &&
                         e.rx_timestamp <= e.now) begin
               received_count++;
               o.rx_counted = 1;
               o.latency_ticks = e.now - e.rx_timestamp;
            end
         endcase
         o.current_rate = rate[39:0];
         pending.push_back(o);
      endfunction

      task check_result(outcome_type g);
         outcome_type w;
         if (pending.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         w = pending.pop_front();
         if (g.tx_valid !== w.tx_valid) report("tx_valid", g.tx_valid, w.tx_valid);
         if (g.tx_timestamp !== w.tx_timestamp)
            report("tx_timestamp", g.tx_timestamp, w.tx_timestamp);
         if (g.tx_length !== w.tx_length) report("tx_length", g.tx_length, w.tx_length);
         if (g.next_kind !== w.next_kind) report("next_kind", g.next_kind, w.next_kind);
         if (g.next_tick !== w.next_tick) report("next_tick", g.next_tick, w.next_tick);
         if (g.current_rate !== w.current_rate)
            report("current_rate", g.current_rate, w.current_rate);
         if (g.rx_counted !== w.rx_counted) report("rx_counted", g.rx_counted, w.rx_counted);
         if (g.latency_ticks !== w.latency_ticks)
            report("latency_ticks", g.latency_ticks, w.latency_ticks);
         if (g.min_rate_hit !== w.min_rate_hit)
            report("min_rate_hit", g.min_rate_hit, w.min_rate_hit);
      endtask
   endclass

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, req_stall;
   logic [1:0]  req_op = OP_START;
   logic [63:0] req_now = 0, req_start_at = 0, req_rx_timestamp = 0;
   logic        req_link_accepted = 0, req_rx_address_match = 0;
   logic [15:0] req_rx_length = 0;
   logic        rsp_valid, rsp_stall = 0;
   logic        rsp_tx_valid, rsp_rx_counted, rsp_min_rate_hit;
   logic [63:0] rsp_tx_timestamp, rsp_next_tick, rsp_latency_ticks;
   logic [15:0] rsp_tx_length;
   logic [1:0]  rsp_next_kind;
   logic [39:0] rsp_current_rate;
   logic        csr_write = 0;
   logic [2:0]  csr_index = CSR_MODE;
   logic [63:0] csr_data = 0;

   adaptive_traffic_generator uut (.*);

   scheduler_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  hold_rsp = 0;
   bit  calm = 0;
   logic [63:0] clock_tick = 0;

   initial forever #10 clock = ~clock;

   function automatic int gap_len();
      if (calm) return 0;
      if ($urandom_range(0, 99) < 60) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // result side: random stall, sample and check at the rising edge
   initial begin
      forever begin
         @(negedge clock);
         rsp_stall <= hold_rsp || (!calm && $urandom_range(0, 99) < 25);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result('{rsp_tx_valid, rsp_tx_timestamp, rsp_tx_length,
                              rsp_next_kind, rsp_next_tick, rsp_current_rate,
                              rsp_rx_counted, rsp_latency_ticks, rsp_min_rate_hit});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIM);
      $display("Regression FAIL");
      $finish;
   end

   // the block stalls new requests while it works on an event, so one idle
   // falling edge between items costs nothing
   task automatic send_event(event_type e);
      int g;
      g = gap_len();
      repeat (g + 1) @(negedge clock);
      req_op <= e.op; req_now <= e.now; req_start_at <= e.start_at;
      req_link_accepted <= e.link_accepted; req_rx_length <= e.rx_length;
      req_rx_address_match <= e.rx_address_match; req_rx_timestamp <= e.rx_timestamp;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sb.note_event(e);
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic drain();
      wait (sb.pending.size() == 0);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] v);
      @(negedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= v;
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_write <= 0;
   endtask

   function automatic event_type make_event(logic [1:0] op, logic [63:0] now);
      event_type e;
      e.op = op; e.now = now;
      e.start_at = $urandom_range(0, 3) == 0 ? rand64() : now + $urandom_range(0, 50);
      e.link_accepted = $urandom_range(0, 4) != 0;
      e.rx_length = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(20, 1500));
      e.rx_address_match = $urandom_range(0, 7) != 0;
      e.rx_timestamp = $urandom_range(0, 9) == 0 ? rand64() : now - $urandom_range(0, 5000);
      return e;
   endfunction

   // follow the block's own schedule, with some noise events
   task automatic run_session(int n);
      event_type e;
      logic [1:0] nk, op;
      for (int i = 0; i < n; i++) begin
         if (i == 0) op = OP_START;
         else if ($urandom_range(0, 99) < 25) op = OP_RX;
         else if ($urandom_range(0, 99) < 6) op = 2'($urandom);
         else if (nk == KIND_LOSS) op = OP_LOSS;
         else op = OP_SEND;
         if ($urandom_range(0, 99) < 3) clock_tick = rand64();
         else clock_tick = clock_tick + $urandom_range(0, 1000);
         e = make_event(op, clock_tick);
         send_event(e);
         if (op == OP_SEND || op == OP_START || op == OP_LOSS) begin
            nk = sb.pending[$].next_kind;
            if (nk != KIND_NONE && sb.pending[$].next_tick >= clock_tick)
               clock_tick = sb.pending[$].next_tick;
         end
      end
   endtask

   task automatic random_setup(int k);
      write_reg(CSR_MODE, k % 4 == 3 ? 64'd3 : 64'(k % 3));
      write_reg(CSR_PACKET, k % 5 == 0 ? 64'($urandom) : 64'($urandom_range(22, 1518)));
      write_reg(CSR_START_RATE, k % 6 == 0 ? {24'd0, 40'($urandom) << 8} :
                64'($urandom_range(1, 1000000000)));
      write_reg(CSR_STOP, k % 3 == 0 ? 64'hFFFF_FFFF_FFFF_FFFF :
                64'($urandom_range(100000, 400000000)));
      write_reg(CSR_LOSS_INT, 64'($urandom_range(1, 40)));
      write_reg(CSR_LOSS_WAIT, k % 7 == 0 ? rand64() : 64'($urandom_range(1, 100000)));
      write_reg(CSR_BURST_W, k % 7 == 1 ? rand64() : 64'($urandom_range(0, 50000)));
      write_reg(CSR_BURST_GAP, k % 7 == 2 ? rand64() : 64'($urandom_range(0, 50000)));
   endtask

   initial begin
      event_type e;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes and special cases, calm handshake
      calm = 1;
      write_reg(CSR_START_RATE, 64'd0);
      write_reg(CSR_STOP, 64'd1000);
      write_reg(CSR_MODE, 64'(MODE_STATIC));
      e = make_event(OP_START, 64'd10); e.start_at = 0; send_event(e);
      e = make_event(OP_START, 64'd10); e.start_at = 64'd1000; send_event(e);
      e = make_event(OP_SEND, 64'd1000); send_event(e);
      e = make_event(OP_SEND, 64'd1001); send_event(e);
      e = make_event(OP_LOSS, 64'd1001); send_event(e);
      e = make_event(OP_SEND, 64'd11); send_event(e);
      e = make_event(OP_RX, 64'd50); e.rx_length = 21; e.rx_address_match = 1;
      e.rx_timestamp = 0; send_event(e);
      e.rx_length = 22; send_event(e);
      e.rx_length = 16'hFFFF; e.rx_address_match = 0; send_event(e);
      e.rx_address_match = 1; e.rx_timestamp = 51; send_event(e);
      e.now = '1; e.rx_timestamp = 0; send_event(e);
      drain();
      write_reg(CSR_START_RATE, 64'hFF_FFFF_FFFF);
      write_reg(CSR_STOP, '1);
      write_reg(CSR_PACKET, 64'd0);
      write_reg(CSR_LOSS_INT, 64'd1);
      write_reg(CSR_LOSS_WAIT, '1);
      write_reg(CSR_MODE, 64'(MODE_INCR));
      e = make_event(OP_START, '1); e.start_at = 0; send_event(e);
      e = make_event(OP_START, 0); e.start_at = 0; send_event(e);
      e = make_event(OP_SEND, 64'd5); e.link_accepted = 1; send_event(e);
      e = make_event(OP_LOSS, 64'd6); send_event(e);
      for (int i = 0; i < 11; i++) begin
         e = make_event(OP_SEND, 64'd7); e.link_accepted = 1; send_event(e);
      end
      e = make_event(OP_LOSS, 64'd9); send_event(e);
      drain();
      write_reg(CSR_MODE, 64'(MODE_BURST));
      write_reg(CSR_BURST_W, '1);
      write_reg(CSR_BURST_GAP, '1);
      write_reg(CSR_START_RATE, 64'd1);
      write_reg(CSR_PACKET, 64'hFFFF);
      e = make_event(OP_START, 64'd100); e.start_at = 0; send_event(e);
      e = make_event(OP_SEND, 64'd50); send_event(e);
      drain();
      write_reg(CSR_BURST_W, 64'd0);
      e = make_event(OP_SEND, 64'd200); send_event(e);
      drain();
      write_reg(CSR_MODE, 64'd3);
      e = make_event(OP_SEND, 64'd300); send_event(e);
      drain();
      calm = 0;

      // random phases, each with its own register setting
      for (int k = 0; k < 16; k++) begin
         random_setup(k);
         clock_tick = $urandom_range(0, 3) == 0 ? rand64() : 64'($urandom);
         if (k == 5) begin
            // long receiver hold-off while events keep coming
            fork
               begin
                  hold_rsp = 1;
                  repeat (400) @(negedge clock);
                  hold_rsp = 0;
               end
               run_session(30);
            join
         end else run_session(69);
         drain();
      end

      repeat (100) @(negedge clock);
      if (fail_count == 0 && sb.pending.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

`default_nettype wire
